/* hdl/assert_macros.svh */
// assertion macros for the rtl files
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define AST_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
// next-cycle implication, checked out of reset
`define AST_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define AST_IMP(label, clk, rst_n, a, b)
`define AST_NXT(label, clk, rst_n, a, b)
`endif
`endif

/* hdl/hff_pkg.sv */
// constants and the digit encoder for the hex field formatter
// no dependencies
`timescale 1ns / 1ps
package hff_pkg;

  localparam int unsigned NIB_W      = 4;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned NUM_DIGITS = VAL_W / NIB_W;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_LOW_A = 8'h61;
  localparam logic [7:0] CHR_UP_A  = 8'h41;

  // ascii code of one hex digit
  function automatic logic [7:0] hex_char(input logic [NIB_W-1:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? CHR_UP_A : CHR_LOW_A;
    if (nib < 4'd10) begin
      hex_char = CHR_ZERO + 8'(nib);
    end else begin
      hex_char = base + 8'(nib - 4'd10);
    end
  endfunction

endpackage

/* hdl/hex_field_formatter_top.sv */
// hex field formatter: one 32-bit value in, its printf-style hex text out
// depends on hff_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel  direction  payload                                       handshake
//  in_      input      value, uppercase, field_width, precision,     in_valid / in_ready
//                      precision_given, left_justify
//  out_     output     character, last_char, total_length            out_valid / out_ready
//
// one item is accepted, then scanned: leading zero nibbles of the value are shifted out
// by the one shared 32-bit shifter until the first digit shows (a zero value keeps one
// digit); then it is sized and sent one character per cycle unless out_ready stalls:
// len = max(width, precision, ndigits) <= MAX_WIDTH characters in all
// rst_n is synchronous, active low; it clears the sequencer and the output valid
// a stalled out_ready holds the output register and the character sequencer
// in_ready is high only while the sequencer is idle; the last character may still
// wait in the output register while the next item is taken
// an empty field (no digits, no padding) gives no transfer at all
module hex_field_formatter_top #(
  parameter int MAX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        in_uppercase,
  input  logic [5:0]  in_field_width,
  input  logic [5:0]  in_precision,
  input  logic        in_precision_given,
  input  logic        in_left_justify,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_character,
  output logic        out_last_char,
  output logic [5:0]  out_total_length
);

  // count width: holds 0..MAX_WIDTH
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);
  localparam int NW = hff_pkg::NIB_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CALC, ST_EMIT} state_t;

  state_t                  state_r, state_nxt;
  logic [hff_pkg::VAL_W-1:0] sh_r, sh_nxt;     // shared shifter, top nibble is next digit
  logic [3:0]              dg_r, dg_nxt;       // digits still to send
  logic                    upper_r, upper_nxt;
  logic                    dot_r, dot_nxt;
  logic                    left_r, left_nxt;
  logic [CW-1:0]           wid_r, wid_nxt;
  logic [CW-1:0]           prec_r, prec_nxt;
  logic [CW-1:0]           zr_r, zr_nxt;       // leading zeros still to send
  logic [CW-1:0]           sp_r, sp_nxt;       // spaces still to send
  logic [CW-1:0]           rem_r, rem_nxt;     // characters still to send
  logic [5:0]              tot_r, tot_nxt;     // field length, 6-bit wrap
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [5:0]              out_len_r, out_len_nxt;

  // sizing terms, used in ST_CALC
  logic [CW-1:0] nd_c, body_c, len_c;
  logic          adv;

  assign adv = !out_valid_r || out_ready;

  always_comb begin
    // digit count is zero for a zero value with an explicit zero precision
    nd_c   = (sh_r == '0 && dot_r && prec_r == '0) ? '0 : CW'(dg_r);
    body_c = (prec_r > nd_c) ? prec_r : nd_c;
    len_c  = (wid_r > body_c) ? wid_r : body_c;
  end

  always_comb begin
    state_nxt     = state_r;
    sh_nxt        = sh_r;
    dg_nxt        = dg_r;
    upper_nxt     = upper_r;
    dot_nxt       = dot_r;
    left_nxt      = left_r;
    wid_nxt       = wid_r;
    prec_nxt      = prec_r;
    zr_nxt        = zr_r;
    sp_nxt        = sp_r;
    rem_nxt       = rem_r;
    tot_nxt       = tot_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;

    // output register drains when taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sh_nxt    = in_value;
          dg_nxt    = 4'(hff_pkg::NUM_DIGITS);
          upper_nxt = in_uppercase;
          dot_nxt   = in_precision_given;
          left_nxt  = in_left_justify;
          // width and precision saturate at MAX_WIDTH
          wid_nxt   = (32'(in_field_width) > 32'(MAX_WIDTH)) ? MAXW : CW'(in_field_width);
          prec_nxt  = (32'(in_precision) > 32'(MAX_WIDTH)) ? MAXW : CW'(in_precision);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // strip one leading zero nibble per cycle, keep at least one digit
        if (sh_r[hff_pkg::VAL_W-1 -: NW] == '0 && dg_r > 4'd1) begin
          sh_nxt = {sh_r[hff_pkg::VAL_W-NW-1:0], {NW{1'b0}}};
          dg_nxt = dg_r - 4'd1;
        end else begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        dg_nxt    = 4'(nd_c);
        zr_nxt    = body_c - nd_c;
        sp_nxt    = len_c - body_c;
        rem_nxt   = len_c;
        tot_nxt   = 6'(len_c);
        state_nxt = (len_c == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (rem_r == CW'(1));
          out_len_nxt   = tot_r;
          if (!left_r && sp_r != '0) begin
            out_char_nxt = hff_pkg::CHR_SPACE;
            sp_nxt       = sp_r - CW'(1);
          end else if (zr_r != '0) begin
            out_char_nxt = hff_pkg::CHR_ZERO;
            zr_nxt       = zr_r - CW'(1);
          end else if (dg_r != '0) begin
            out_char_nxt = hff_pkg::hex_char(sh_r[hff_pkg::VAL_W-1 -: NW], upper_r);
            sh_nxt       = {sh_r[hff_pkg::VAL_W-NW-1:0], {NW{1'b0}}};
            dg_nxt       = dg_r - 4'd1;
          end else begin
            // trailing spaces of a left-justified field
            out_char_nxt = hff_pkg::CHR_SPACE;
            sp_nxt       = sp_r - CW'(1);
          end
          rem_nxt = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sh_r       <= sh_nxt;
    dg_r       <= dg_nxt;
    upper_r    <= upper_nxt;
    dot_r      <= dot_nxt;
    left_r     <= left_nxt;
    wid_r      <= wid_nxt;
    prec_r     <= prec_nxt;
    zr_r       <= zr_nxt;
    sp_r       <= sp_nxt;
    rem_r      <= rem_nxt;
    tot_r      <= tot_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_character    = out_char_r;
  assign out_last_char    = out_last_r;
  assign out_total_length = out_len_r;

  // in ST_EMIT the three padding and digit counters add up to what is left to send
  logic [CW:0] cnt_sum;
  assign cnt_sum = (CW+1)'(sp_r) + (CW+1)'(zr_r) + (CW+1)'(dg_r);

  `AST_IMP(a_emit_nonempty, clk, rst_n, state_r == ST_EMIT, rem_r != '0)
  `AST_IMP(a_cnt_sum, clk, rst_n, state_r == ST_EMIT, cnt_sum == (CW+1)'(rem_r))
  `AST_NXT(a_accept_scan, clk, rst_n, in_valid && in_ready, state_r == ST_SCAN)
  `AST_NXT(a_last_done, clk, rst_n,
           state_r == ST_EMIT && adv && rem_r == CW'(1),
           state_r == ST_IDLE && out_valid_r && out_last_r)

endmodule
